// ----- design/iialu_pkg.sv -----
// Package for the iterative integer ALU: operation and status codes, widths.
// No dependencies.
package iialu_pkg;
	localparam int DW = 32;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_SQRT = 4'd4,
		OP_HYP = 4'd5, OP_AREA = 4'd6, OP_FACT = 4'd7, OP_POW = 4'd8
	} op_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DIV_ERR = 2'd1;
	localparam logic [1:0] ST_HYP_SAT = 2'd2;

	// datapath commands
	typedef enum logic [2:0] {
		CMD_NONE, CMD_LOAD, CMD_DIV_STEP, CMD_SQRT_STEP, CMD_MUL_STEP, CMD_HYP_SQ, CMD_FINISH
	} cmd_t;

	typedef struct packed {
		logic       quick;    // result settles at load
		logic       is_div;
		logic       is_root;  // sqrt or hypotenuse
		logic       is_hyp;
		logic       is_mul;   // factorial or power loop
		logic       loop_done;
	} dp_status_t;
endpackage

// ----- design/iterative_integer_alu_top.sv -----
// Top level of the iterative integer ALU.
// Depends on iialu_pkg, iialu_ctrl and iialu_datapath.
//
// Usage: raise start with operation, operand_a and operand_b while busy is low;
// the request is taken at that edge and busy rises. One result follows per
// request on result and status, shown for one cycle with done high; the
// receiver cannot hold it off. busy falls the cycle after done.
// Factorial does one multiply per factor and power one multiply per exponent
// bit step, both on the shared multiplier.
// One request at a time; the next may start as busy falls.
// Reset (arst_n low) returns the controller to idle and drops busy and done.
module iterative_integer_alu_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [3:0]  operation,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output logic        busy,
	output logic        done,
	output logic [31:0] result,
	output logic [1:0]  status
);
	import iialu_pkg::*;

	cmd_t       cmd;
	dp_status_t sts;

	iialu_ctrl u_ctrl (.clk, .arst_n, .start, .sts, .cmd, .busy, .done);
	iialu_datapath u_dp (.clk, .cmd, .operation, .operand_a, .operand_b, .sts,
		.res(result), .st(status));
endmodule

// ----- design/iialu_datapath.sv -----
// Datapath: operand registers, one shared 32x32 multiplier, restoring divider
// and digit-by-digit root unit. Depends on iialu_pkg.
module iialu_datapath (
	input  logic                  clk,
	input  iialu_pkg::cmd_t       cmd,
	input  logic [3:0]            operation,
	input  logic [31:0]           operand_a,
	input  logic [31:0]           operand_b,
	output iialu_pkg::dp_status_t sts,
	output logic [31:0]           res,
	output logic [1:0]            st
);
	import iialu_pkg::*;

	logic [3:0]  op_q;
	logic [31:0] a_q, b_q;
	logic [31:0] acc_q, base_q, cnt_q;   // cnt: factorial n or exponent
	logic [63:0] rem_q, rad_q;           // div/root remainder, radicand
	logic [31:0] root_q;
	logic [5:0]  step_q;
	logic [31:0] res_q;
	logic [1:0]  st_q;
	logic        quick_q;

	logic [31:0] mag_a, mag_b, mul_x, mul_y;
	logic [63:0] prod;
	logic [63:0] trial, rem_sh;
	logic [33:0] rtrial;
	logic [65:0] rrem_sh;

	// values taken at load
	logic [31:0] ld_res, ld_cnt;
	logic [63:0] ld_rad;
	logic [1:0]  ld_st;
	logic        ld_quick;
	logic        op_is_root;

	assign mag_a = a_q[31] ? (32'd0 - a_q) : a_q;
	assign mag_b = b_q[31] ? (32'd0 - b_q) : b_q;

	always_comb begin
		mul_x = acc_q;
		mul_y = base_q;
		if (cmd == CMD_HYP_SQ) begin
			mul_x = (step_q[0]) ? mag_b : mag_a;
			mul_y = mul_x;
		end else if (op_q == OP_MUL || op_q == OP_AREA) begin
			mul_x = a_q;
			mul_y = b_q;
		end else if (op_q == OP_FACT) begin
			mul_y = cnt_q;
		end else if (!cnt_q[0]) begin
			mul_x = base_q;
		end
	end
	assign prod = mul_x * mul_y;

	// divide: one quotient bit a step, dividend shifted through rad_q
	assign rem_sh = {rem_q[62:0], rad_q[31]};
	assign trial  = rem_sh - {32'd0, b_q};
	// root: two radicand bits a step
	assign rrem_sh = {rem_q, rad_q[63:62]};
	assign rtrial  = {root_q, 2'b01};

	always_comb begin
		ld_res = '0;
		ld_st = ST_OK;
		ld_quick = 1'b1;
		ld_rad = {32'd0, operand_a};
		ld_cnt = operand_b;
		case (operation)
		OP_ADD: ld_res = operand_a + operand_b;
		OP_SUB: ld_res = operand_a - operand_b;
		OP_MUL, OP_AREA: ld_quick = 1'b0;
		OP_DIV: begin
			if (!operand_a[31] && operand_a != 0) begin
				if (operand_b[31] || operand_b == 0) ld_st = ST_DIV_ERR;
				else ld_quick = 1'b0;
			end
		end
		OP_SQRT: begin
			if (!operand_a[31] && operand_a != 0) ld_quick = 1'b0;
		end
		OP_HYP: begin ld_quick = 1'b0; ld_rad = '0; end
		OP_FACT: begin
			if ($signed(operand_a) <= 32'sd1) ld_res = 32'd1;
			else if ($signed(operand_a) >= 32'sd64) ld_res = 32'd0;
			else begin ld_quick = 1'b0; ld_cnt = operand_a; end
		end
		OP_POW: begin
			if (operand_b == 0) ld_res = 32'd1;
			else if ($signed(operand_b) <= 32'sd1) ld_res = operand_a;
			else ld_quick = 1'b0;
		end
		default: ld_res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		case (cmd)
		CMD_LOAD: begin
			op_q <= operation; a_q <= operand_a; b_q <= operand_b;
			acc_q <= 32'd1; base_q <= operand_a; cnt_q <= ld_cnt;
			rem_q <= '0; root_q <= '0; step_q <= '0; st_q <= ld_st; quick_q <= ld_quick;
			rad_q <= ld_rad;
			res_q <= ld_res;
		end
		CMD_FINISH: begin
			case (op_q)
			OP_MUL, OP_AREA: res_q <= prod[31:0];
			OP_DIV: res_q <= rad_q[31:0];
			OP_SQRT: res_q <= root_q;
			OP_HYP: begin
				if (root_q[31]) begin res_q <= 32'h7fff_ffff; st_q <= ST_HYP_SAT; end
				else res_q <= root_q;
			end
			OP_FACT, OP_POW: res_q <= acc_q;
			default: res_q <= res_q;
			endcase
		end
		CMD_HYP_SQ: begin
			rad_q <= rad_q + prod;
			step_q <= step_q + 6'd1;
		end
		CMD_DIV_STEP: begin
			if (!trial[63]) rem_q <= trial; else rem_q <= rem_sh;
			rad_q <= {32'd0, rad_q[30:0], ~trial[63]};
			step_q <= step_q + 6'd1;
		end
		CMD_SQRT_STEP: begin
			if (rrem_sh[65:0] >= {32'd0, rtrial}) begin
				rem_q <= 64'(rrem_sh - {32'd0, rtrial});
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q <= rrem_sh[63:0];
				root_q <= {root_q[30:0], 1'b0};
			end
			rad_q <= {rad_q[61:0], 2'b00};
			step_q <= step_q + 6'd1;
		end
		CMD_MUL_STEP: begin
			if (op_q == OP_FACT) begin
				acc_q <= prod[31:0];
				cnt_q <= cnt_q - 32'd1;
			end else begin
				// square-and-multiply, exponent bits from LSB
				if (cnt_q[0]) begin
					acc_q <= prod[31:0]; cnt_q <= {cnt_q[31:1], 1'b0};
				end else begin
					base_q <= prod[31:0]; cnt_q <= {1'b0, cnt_q[31:1]};
				end
			end
		end
		default: ;
		endcase
	end

	assign op_is_root = (op_q == OP_SQRT) || (op_q == OP_HYP);

	// hypotenuse: two squaring steps come first, then 32 root steps
	always_comb begin
		sts.quick = quick_q;
		sts.is_div = (op_q == OP_DIV);
		sts.is_root = op_is_root;
		sts.is_hyp = (op_q == OP_HYP);
		sts.is_mul = (op_q == OP_FACT) || (op_q == OP_POW);
		sts.loop_done = 1'b0;
		if (op_q == OP_FACT) sts.loop_done = (cnt_q[31:1] == 31'd0);
		else if (op_q == OP_POW) sts.loop_done = (cnt_q == 32'd0);
		else if (op_q == OP_DIV) sts.loop_done = (step_q == 6'd32);
		else if (op_q == OP_HYP) sts.loop_done = (step_q == 6'd34);
		else if (op_is_root) sts.loop_done = (step_q == 6'd32);
	end

	assign res = res_q;
	assign st  = st_q;
endmodule

// ----- design/iialu_ctrl.sv -----
// Controller state machine: sequences load, iteration and finish commands.
// Depends on iialu_pkg.
module iialu_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  iialu_pkg::dp_status_t sts,
	output iialu_pkg::cmd_t       cmd,
	output logic                  busy,
	output logic                  done
);
	import iialu_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_HYP, S_ITER, S_FIN, S_OUT} state_t;
	state_t state_q;
	logic [5:0] hcnt_q;

	always_comb begin
		cmd = CMD_NONE;
		case (state_q)
		S_IDLE: if (start) cmd = CMD_LOAD;
		S_HYP: cmd = CMD_HYP_SQ;
		S_ITER: begin
			if (!sts.loop_done) begin
				if (sts.is_div) cmd = CMD_DIV_STEP;
				else if (sts.is_root) cmd = CMD_SQRT_STEP;
				else cmd = CMD_MUL_STEP;
			end
		end
		S_FIN: cmd = CMD_FINISH;
		default: cmd = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; busy <= 1'b0; done <= 1'b0; hcnt_q <= '0;
		end else begin
			case (state_q)
			S_IDLE: if (start) begin state_q <= S_DECIDE; busy <= 1'b1; end
			S_DECIDE: begin
				done <= sts.quick;
				if (sts.quick) state_q <= S_OUT;
				else if (sts.is_hyp) begin state_q <= S_HYP; hcnt_q <= '0; end
				else if (sts.is_div || sts.is_root || sts.is_mul) state_q <= S_ITER;
				else state_q <= S_FIN;
			end
			S_HYP: begin
				hcnt_q <= hcnt_q + 6'd1;
				if (hcnt_q[0]) state_q <= S_ITER;
			end
			S_ITER: if (sts.loop_done) state_q <= S_FIN;
			S_FIN: begin state_q <= S_OUT; done <= 1'b1; end
			S_OUT: begin state_q <= S_IDLE; busy <= 1'b0; done <= 1'b0; end
			default: begin state_q <= S_IDLE; done <= 1'b0; end
			endcase
		end
	end

`ifndef SYNTH
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("strobe outside busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("strobe longer than a cycle");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_LOAD) |-> !busy) else $error("load while busy");
`endif
endmodule

// ----- tb/iterative_integer_alu_top_tb.sv -----
// Testbench for iterative_integer_alu_top: directed and random requests, each result
// checked against an in-bench model of every operation. Depends on iialu_pkg.
module iterative_integer_alu_top_tb;
	import iialu_pkg::*;

	typedef struct {
		logic [31:0] result;
		logic [1:0]  status;
	} alu_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [3:0]  operation = 4'd0;
	logic [31:0] operand_a = 32'd0;
	logic [31:0] operand_b = 32'd0;
	logic        busy, done;
	logic [31:0] result;
	logic [1:0]  status;

	alu_out_t    pending_q[$];
	int          errors = 0;
	int          idle_cycles = 0;
	bit          gaps_on = 1'b1;

	localparam int WATCHDOG = 5000;

	iterative_integer_alu_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .operation(operation),
		.operand_a(operand_a), .operand_b(operand_b), .busy(busy), .done(done),
		.result(result), .status(status)
	);

	always #1 clk = ~clk;

	function automatic logic [63:0] isqrt(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic alu_out_t alu_predict(logic [3:0] op, logic [31:0] ua, logic [31:0] ub);
		alu_out_t o;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic [63:0] ma, mb, r;
		logic [31:0] acc, base, e;
		a = ua;
		b = ub;
		o.result = 32'd0;
		o.status = ST_OK;
		case (op)
			OP_ADD: o.result = ua + ub;
			OP_SUB: o.result = ua - ub;
			OP_MUL, OP_AREA: o.result = ua * ub;
			OP_DIV: begin
				if (a > 0) begin
					if (b > 0) o.result = ua / ub;
					else o.status = ST_DIV_ERR;
				end
			end
			OP_SQRT: if (a > 0) o.result = isqrt({32'd0, ua});
			OP_HYP: begin
				ma = a < 0 ? -64'(a) : 64'(a);
				mb = b < 0 ? -64'(b) : 64'(b);
				r = isqrt(ma * ma + mb * mb);
				if (r > 64'h7FFF_FFFF) begin
					r = 64'h7FFF_FFFF;
					o.status = ST_HYP_SAT;
				end
				o.result = r[31:0];
			end
			OP_FACT: begin
				acc = 1;
				if (a > 1 && a < 64)
					for (int n = a; n > 1; n--) acc = acc * n;
				else if (a >= 64) acc = 0;
				o.result = acc;
			end
			OP_POW: begin
				if (b == 0) o.result = 1;
				else if (b <= 1) o.result = ua;
				else begin
					acc = 1;
					base = ua;
					e = ub;
					while (e != 0) begin
						if (e[0]) acc = acc * base;
						base = base * base;
						e = e >> 1;
					end
					o.result = acc;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// result checker and watchdog
	always @(posedge clk) begin
		alu_out_t x;
		if (arst_n) begin
			if ((start && !busy) || done) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("%0t watchdog timeout", $time);
				$display("[iterative_integer_alu_top] ERROR");
				$finish;
			end
			if (done) begin
				if (pending_q.size() == 0) begin
					$display("%0t unexpected result %h status %0d", $time, result, status);
					errors++;
				end else begin
					x = pending_q.pop_front();
					if (x.result !== result) begin
						$display("%0t result exp %h got %h", $time, x.result, result);
						errors++;
					end
					if (x.status !== status) begin
						$display("%0t status exp %0d got %0d", $time, x.status, status);
						errors++;
					end
				end
			end
		end
	end

	// busy is low at this falling edge, so the request is taken at the next rising edge
	task automatic send_request(logic [3:0] op, logic [31:0] a, logic [31:0] b);
		int gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			repeat (gap) @(negedge clk);
		end
		while (busy) @(negedge clk);
		start <= 1'b1;
		operation <= op;
		operand_a <= a;
		operand_b <= b;
		pending_q.push_back(alu_predict(op, a, b));
		@(posedge clk);
		@(negedge clk);
		start <= 1'b0;
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000 + $urandom_range(0, 2);
			1: return 32'h7FFF_FFFF - $urandom_range(0, 2);
			2: return $urandom_range(0, 70);
			3: return -$urandom_range(0, 70);
			4: return $urandom_range(0, 65535);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		logic [31:0] ext[6] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'd2};
		for (int op = 0; op <= 8; op++)
			send_request(4'(op), ext[op % 6], ext[(op + 3) % 6]);
		send_request(OP_DIV, 32'hFFFF_FFF6, 32'd3);      // nonpositive dividend
		send_request(OP_DIV, 32'd10, 32'd0);             // divide by zero
		send_request(OP_DIV, 32'd10, 32'hFFFF_FFFE);     // negative divisor
		send_request(OP_DIV, 32'h7FFF_FFFF, 32'd1);
		send_request(OP_SQRT, 32'h8000_0000, 32'd0);     // negative radicand
		send_request(OP_SQRT, 32'h7FFF_FFFF, 32'd5);
		send_request(OP_HYP, 32'h8000_0000, 32'h8000_0000); // saturates
		send_request(OP_HYP, 32'd3, 32'hFFFF_FFFC);
		send_request(OP_FACT, 32'd12, 32'd0);
		send_request(OP_FACT, 32'd63, 32'd0);
		send_request(OP_FACT, 32'h7FFF_FFFF, 32'd0);
		send_request(OP_POW, 32'd3, 32'd0);              // zero exponent
		send_request(OP_POW, 32'd3, 32'h8000_0000);      // negative exponent
		send_request(OP_POW, 32'hFFFF_FFFD, 32'h7FFF_FFFF);
		send_request(4'd9, 32'd5, 32'd5);                // unused codes
		send_request(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			send_request($urandom_range(0, 15) < 14 ? 4'($urandom_range(0, 8))
				: 4'($urandom_range(9, 15)), pick_operand(), pick_operand());
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(1200);
		gaps_on = 1'b0;
		test_random(300);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (errors == 0) $display("[iterative_integer_alu_top] OK");
		else $display("[iterative_integer_alu_top] ERROR");
		$finish;
	end
endmodule

// ----- filelist.f -----
design/iialu_pkg.sv
design/iialu_datapath.sv
design/iialu_ctrl.sv
design/iterative_integer_alu_top.sv
tb/iterative_integer_alu_top_tb.sv
